/* hw/rtl/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and codes of the masked rectangle OR compositor.
// ----------------------------------------------------------------------------
package mrc_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_EXCL  = 3'd1,
    MODE_START = 3'd2,
    MODE_BYTE  = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXCLUDED = 3'd1,
    ST_OOB      = 3'd2,
    ST_NO_PATCH = 3'd3,
    ST_BAD_ID   = 3'd4
  } status_e;

  // configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [6:0] GRID_DIM_RESET = 7'd64;

  // commands into the patch cursor
  typedef struct packed {
    logic       start;
    logic       advance;
    logic       cancel;
    logic [5:0] ox;
    logic [5:0] oy;
    logic [6:0] w;
    logic [6:0] h;
  } cur_cmd_t;

  // current target cell of the active patch
  typedef struct packed {
    logic       active;
    logic       last;
    logic [7:0] col;
    logic [7:0] row;
  } cur_pos_t;

endpackage

/* hw/rtl/mrc_ram.sv */
// ----------------------------------------------------------------------------
// mrc_ram
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mrc_cursor.sv */
// ----------------------------------------------------------------------------
// mrc_cursor
// Active patch rectangle and its row-major write cursor.
// ----------------------------------------------------------------------------
module mrc_cursor import mrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cur_cmd_t cmd_i,
  output cur_pos_t pos_o
);

  logic [5:0] ox_q, oy_q;
  logic [6:0] w_q, h_q;
  logic [6:0] col_q, row_q;
  logic       active_q;
  logic [7:0] col_nx, row_nx;
  logic       wrap_col, wrap_row;

  assign col_nx   = {1'b0, col_q} + 8'd1;
  assign row_nx   = {1'b0, row_q} + 8'd1;
  assign wrap_col = col_nx >= {1'b0, w_q};
  assign wrap_row = row_nx >= {1'b0, h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      w_q      <= '0;
      h_q      <= '0;
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
    end else if (cmd_i.cancel) begin
      active_q <= 1'b0;
    end else if (cmd_i.start) begin
      ox_q     <= cmd_i.ox;
      oy_q     <= cmd_i.oy;
      w_q      <= cmd_i.w;
      h_q      <= cmd_i.h;
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b1;
    end else if (cmd_i.advance) begin
      if (wrap_col) begin
        col_q <= '0;
        if (wrap_row) begin
          row_q    <= '0;
          active_q <= 1'b0;
        end else begin
          row_q <= row_nx[6:0];
        end
      end else begin
        col_q <= col_nx[6:0];
      end
    end
  end

  assign pos_o.active = active_q;
  assign pos_o.last   = wrap_col && wrap_row;
  assign pos_o.col    = {2'b00, ox_q} + {1'b0, col_q};
  assign pos_o.row    = {2'b00, oy_q} + {1'b0, row_q};

endmodule

/* hw/rtl/masked_rect_or_compositor.sv */
// ----------------------------------------------------------------------------
// masked_rect_or_compositor
// Byte grid compositor: clears, region exclusion, OR-patching of rectangles
// in row-major order and single cell reads, on a grid held in block RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_stall_o | mode, region_id, rect_*, patch_value
//  out     | source    | out_valid_o/out_stall_i | status, cell_value,
//          |           |                       | patches_written, patch_done
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each beat passes through accept, address + RAM read, and execute + write
// back. The next beat can be taken in the execute state as the current one
// finishes, except after a clear. Reset and every clear run a zeroing sweep
// over max(MAX_WIDTH*MAX_HEIGHT, ID_COUNT) addresses (4096 by default) with
// in_stall_o high.
// Execute waits while the output register is full and stalled.
// ----------------------------------------------------------------------------
module masked_rect_or_compositor import mrc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int ID_COUNT   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] region_id_i,
  input  logic [5:0] rect_x_i,
  input  logic [5:0] rect_y_i,
  input  logic [6:0] rect_w_i,
  input  logic [6:0] rect_h_i,
  input  logic [7:0] patch_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] cell_value_o,
  output logic [7:0] patches_written_o,
  output logic       patch_done_o
);

  localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SWEEP      = (GRID_DEPTH > ID_COUNT) ? GRID_DEPTH : ID_COUNT;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int IDW        = $clog2(ID_COUNT);
  localparam int SW         = $clog2(SWEEP);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int MW         = (WW > HW) ? WW : HW;
  localparam int CW         = ((MW > 8) ? MW : 8) + 1;
  localparam int PW         = 8 + WW + 1;
  localparam logic [SW-1:0] SWEEP_LAST = SW'(SWEEP - 1);
  localparam logic [SW:0]   GRID_LIM   = (SW+1)'(GRID_DEPTH);
  localparam logic [SW:0]   ID_LIM     = (SW+1)'(ID_COUNT);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_ADDR,
    S_EXEC
  } state_e;

  state_e       state_q;
  logic [SW-1:0] sweep_q;
  logic [7:0]   acc_q;
  logic         out_valid_q;
  logic [2:0]   status_q;
  logic [7:0]   cell_q;
  logic [7:0]   count_q;
  logic         done_q;

  logic [6:0] gwidth_q, gheight_q;

  logic [2:0] mode_q;
  logic [7:0] id_q;
  logic [5:0] x_q, y_q;
  logic [6:0] w_q, h_q;
  logic [7:0] val_q;

  logic [AW-1:0] addr_q;
  logic          in_grid_q;

  logic [WW-1:0] gw;
  logic [HW-1:0] gh;
  logic          can_finish, fire, in_acc, id_ok;
  logic [7:0]    tcol, trow;
  logic          in_grid;
  logic [PW-1:0] lin_addr;

  cur_cmd_t cmd, cmd_raw;
  cur_pos_t pos;

  logic          grid_we, grid_we_exec, sweep_grid_we;
  logic [AW-1:0] grid_waddr;
  logic [7:0]    grid_wdata, grid_rd;
  logic          excl_we, excl_we_exec, sweep_excl_we, excl_re;
  logic [IDW-1:0] excl_waddr;
  logic [0:0]    excl_wdata, excl_rd;

  status_e    st_d;
  logic [7:0] cell_d, acc_d;
  logic       done_d;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gwidth_q  <= GRID_DIM_RESET;
      gheight_q <= GRID_DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_GRID_WIDTH) begin
        gwidth_q <= cfg_data_i;
      end else begin
        gheight_q <= cfg_data_i;
      end
    end
  end

  assign gw = (CW'(gwidth_q) > CW'(MAX_WIDTH))   ? WW'(MAX_WIDTH)  : WW'(gwidth_q);
  assign gh = (CW'(gheight_q) > CW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(gheight_q);

  // ---------------------------------------------------------------- intake
  assign can_finish = !out_valid_q || !out_stall_i;
  assign fire       = (state_q == S_EXEC) && can_finish;
  assign in_stall_o = !((state_q == S_IDLE) ||
                        (fire && (mode_q != MODE_CLEAR)));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      id_q   <= region_id_i;
      x_q    <= rect_x_i;
      y_q    <= rect_y_i;
      w_q    <= rect_w_i;
      h_q    <= rect_h_i;
      val_q  <= patch_value_i;
    end
  end

  assign id_ok = (id_q != 8'd0) && (9'({1'b0, id_q}) < 9'(ID_COUNT));

  // ---------------------------------------------------------------- address
  assign tcol     = (mode_q == MODE_BYTE) ? pos.col : {2'b00, x_q};
  assign trow     = (mode_q == MODE_BYTE) ? pos.row : {2'b00, y_q};
  assign in_grid  = (CW'(tcol) < CW'(gw)) && (CW'(trow) < CW'(gh));
  assign lin_addr = PW'(trow) * PW'(gw) + PW'(tcol);

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      addr_q    <= lin_addr[AW-1:0];
      in_grid_q <= in_grid;
    end
  end

  // The write of one beat lands at its execute edge, before the next beat's
  // address cycle issues its read, so same-cell accesses never overlap.
  assign sweep_grid_we = (state_q == S_SWEEP) && ({1'b0, sweep_q} < GRID_LIM);
  assign grid_we       = sweep_grid_we || (fire && grid_we_exec);
  assign grid_waddr    = (state_q == S_SWEEP) ? sweep_q[AW-1:0] : addr_q;
  assign grid_wdata    = (state_q == S_SWEEP) ? 8'd0 : (grid_rd | val_q);

  mrc_ram #(
    .WIDTH(8),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (state_q == S_ADDR),
    .raddr_i (lin_addr[AW-1:0]),
    .rdata_o (grid_rd)
  );

  assign sweep_excl_we = (state_q == S_SWEEP) && ({1'b0, sweep_q} < ID_LIM);
  assign excl_we       = sweep_excl_we || (fire && excl_we_exec);
  assign excl_waddr    = (state_q == S_SWEEP) ? sweep_q[IDW-1:0] : id_q[IDW-1:0];
  assign excl_wdata    = (state_q == S_SWEEP) ? 1'b0 : 1'b1;
  assign excl_re       = (state_q == S_ADDR) && id_ok;

  mrc_ram #(
    .WIDTH(1),
    .DEPTH(ID_COUNT)
  ) u_excl (
    .clk_i   (clk_i),
    .we_i    (excl_we),
    .waddr_i (excl_waddr),
    .wdata_i (excl_wdata),
    .re_i    (excl_re),
    .raddr_i (id_q[IDW-1:0]),
    .rdata_o (excl_rd)
  );

  // ---------------------------------------------------------------- execute
  always_comb begin
    st_d         = ST_OK;
    cell_d       = 8'd0;
    done_d       = 1'b0;
    acc_d        = acc_q;
    grid_we_exec = 1'b0;
    excl_we_exec = 1'b0;
    cmd_raw      = '0;
    cmd_raw.ox   = x_q;
    cmd_raw.oy   = y_q;
    cmd_raw.w    = w_q;
    cmd_raw.h    = h_q;
    case (mode_q)
      MODE_CLEAR: begin
        acc_d          = 8'd0;
        cmd_raw.cancel = 1'b1;
      end
      MODE_EXCL: begin
        if (!id_ok) begin
          st_d = ST_BAD_ID;
        end else begin
          excl_we_exec = 1'b1;
        end
      end
      MODE_START: begin
        if (!id_ok) begin
          st_d = ST_BAD_ID;
        end else if (excl_rd[0]) begin
          st_d = ST_EXCLUDED;
        end else if ((w_q == 7'd0) || (h_q == 7'd0) ||
                     (CW'(x_q) + CW'(w_q) > CW'(gw)) ||
                     (CW'(y_q) + CW'(h_q) > CW'(gh))) begin
          st_d = ST_OOB;
        end else begin
          cmd_raw.start = 1'b1;
          if (acc_q != 8'hFF) begin
            acc_d = acc_q + 8'd1;
          end
        end
      end
      MODE_BYTE: begin
        if (!pos.active) begin
          st_d = ST_NO_PATCH;
        end else begin
          cmd_raw.advance = 1'b1;
          done_d          = pos.last;
          if (in_grid_q) begin
            grid_we_exec = 1'b1;
            cell_d       = grid_rd | val_q;
          end else begin
            st_d = ST_OOB;
          end
        end
      end
      MODE_READ: begin
        if (in_grid_q) begin
          cell_d = grid_rd;
        end else begin
          st_d = ST_OOB;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd         = cmd_raw;
    cmd.start   = cmd_raw.start   && fire;
    cmd.advance = cmd_raw.advance && fire;
    cmd.cancel  = cmd_raw.cancel  && fire;
  end

  mrc_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pos_o  (pos)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      acc_q       <= 8'd0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      cell_q      <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        status_q    <= st_d;
        cell_q      <= cell_d;
        count_q     <= acc_d;
        done_q      <= done_d;
        acc_q       <= acc_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == SWEEP_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (can_finish) begin
            if (mode_q == MODE_CLEAR) begin
              state_q <= S_SWEEP;
              sweep_q <= '0;
            end else if (in_acc) begin
              state_q <= S_ADDR;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign cell_value_o      = cell_q;
  assign patches_written_o = count_q;
  assign patch_done_o      = done_q;

endmodule

/* hw/rtl/mrc_checker.sv */
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks of the compositor, bound to the top level.
// ----------------------------------------------------------------------------
module mrc_checker import mrc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [7:0] cell_value_o,
  input logic       patch_done_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one beat in flight: the address cycle always follows an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during address cycle");

  // refused or idle commands never report cell data
  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) && (status_o != ST_OOB)
      |-> (cell_value_o == 8'd0) && !patch_done_o)
    else $error("cell data on refused command");

  // a completing byte is either written or off the grid
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && patch_done_o |-> (status_o == ST_OK) || (status_o == ST_OOB))
    else $error("patch completion with bad status");

endmodule

bind masked_rect_or_compositor mrc_checker u_mrc_checker (.*);
